### hdl/tensor_fourier_feature_expand_defines.svh
// assertion helpers for the feature expansion block
`ifndef TENSOR_FOURIER_FEATURE_EXPAND_DEFINES_SVH
`define TENSOR_FOURIER_FEATURE_EXPAND_DEFINES_SVH

// checked only while out of reset
`define TFFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define TFFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tffe_pkg.sv
package tffe_pkg;

    localparam int SERIES_DEPTH_DEF = 64;
    localparam int MAX_DIM_DEF      = 16;

    localparam int CFG_W = 16;

    typedef enum logic [1:0] {
        REG_DIMENSION  = 2'd0,
        REG_SERIES_LEN = 2'd1,
        REG_MAX_K      = 2'd2,
        REG_FREQ_STEP  = 2'd3
    } t_reg_idx;

    localparam logic signed [15:0] ONE_Q14         = 16'sd16384;
    localparam logic signed [30:0] INV2PI_Q32      = 31'sd683565276;
    localparam logic        [30:0] PI_HALF_Q30     = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam int                 CORDIC_ITERS    = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_BASE1,
        S_BASE2,
        S_BASE3,
        S_HARM,
        S_ZMUL,
        S_ROT,
        S_TRIG,
        S_RD,
        S_WAIT,
        S_EMIT
    } t_state;

    function automatic logic [31:0] atan_q30(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'h3243F6A8;
            4'd1:    r = 32'h1DAC6705;
            4'd2:    r = 32'h0FADBAFC;
            4'd3:    r = 32'h07F56EA6;
            4'd4:    r = 32'h03FEAB76;
            4'd5:    r = 32'h01FFD55B;
            4'd6:    r = 32'h00FFFAAA;
            4'd7:    r = 32'h007FFF55;
            4'd8:    r = 32'h003FFFEA;
            4'd9:    r = 32'h001FFFFD;
            4'd10:   r = 32'h000FFFFF;
            4'd11:   r = 32'h0007FFFF;
            4'd12:   r = 32'h0003FFFF;
            4'd13:   r = 32'h0001FFFF;
            4'd14:   r = 32'h0000FFFF;
            4'd15:   r = 32'h00007FFF;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

### hdl/tffe_ram.sv
module tffe_ram import tffe_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = SERIES_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tensor_fourier_feature_expand.sv
// tensor-product fourier feature expansion
// input stream: one signed q3.12 coordinate per item on i_s_*, accepted when
// i_s_tvalid and o_s_tready are both high. o_s_tready is high only while the
// block is idle: one coordinate is worked on at a time.
// output stream: series entries on o_m_*, several per coordinate; o_m_tlast
// marks the final entry of a coordinate, o_m_tuser marks the entry that
// completes the series. a coordinate may give no entries at all.
// sequence: entry 0 (first coordinate of a vector) is loaded in S_HEAD
// after accept, once the output register is free; the base phase runs
// S_BASE1 to S_BASE3; each harmonic runs cordic set-up and rotation (one
// shared shift-add stage, 16 rotations), then the cosine and sine passes;
// each product goes S_RD, S_WAIT, S_EMIT through the registered-read
// series store and the multiplier. a stalled receiver holds the output
// register and the sequencer waits on it. reset (i_rst_n low, synchronous)
// restores the register defaults, clears the output and returns to idle;
// the series store is not cleared since only entries written in the current
// series are read. configuration: i_cfg_we writes i_cfg_data to register
// i_cfg_addr; the user writes only while idle, which the block itself
// does not enforce.
module tensor_fourier_feature_expand import tffe_pkg::*; #(
    parameter int SERIES_DEPTH = SERIES_DEPTH_DEF,
    parameter int MAX_DIM      = MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,   // coord
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,   // value, position, zero pad
    output logic              o_m_tlast,
    output logic              o_m_tuser    // series_done
);

    localparam int AW = $clog2(SERIES_DEPTH);
    localparam int PW = $clog2(SERIES_DEPTH + 1);

    t_state r_state, n_state;

    logic [4:0]  r_dim, r_maxk;
    logic [6:0]  r_len;
    logic [15:0] r_fstep;

    logic [4:0]           r_cc, n_cc;
    logic [PW-1:0]        r_wp, n_wp, r_filled, n_filled, r_j, n_j;
    logic signed [15:0]   r_coord, n_coord;
    logic signed [31:0]   r_p1, n_p1;
    logic signed [61:0]   r_q, n_q;
    logic [31:0]          r_base, n_base, r_phase, n_phase;
    logic [4:0]           r_k, n_k;
    logic [1:0]           r_quad, n_quad;
    logic signed [33:0]   r_x, n_x, r_y, n_y, r_cos, n_cos, r_sin, n_sin;
    logic signed [32:0]   r_z, n_z;
    logic [3:0]           r_i, n_i;
    logic                 r_pass, n_pass;
    logic signed [49:0]   r_mp, n_mp;

    logic                 r_ov, n_ov, r_olast, n_olast, r_odone, n_odone;
    logic [15:0]          r_oval, n_oval;
    logic [5:0]           r_opos, n_opos;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [15:0]          ram_wdata, ram_rdata;

    logic [4:0]           dim_c, cc0, cc_inc;
    logic [6:0]           len_c, wp7, filled7, j7;
    logic                 out_free, more;
    logic signed [61:0]   q_rnd;
    logic [60:0]          zprod;
    logic signed [33:0]   dx, dy, t_sel;
    logic signed [32:0]   at;
    logic signed [49:0]   t_ext, d_ext, mp_rnd, mp_sh;
    logic signed [15:0]   v_sat;

    tffe_ram #(.WIDTH(16), .DEPTH(SERIES_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 5'd1;
            r_len   <= 7'd64;
            r_maxk  <= 5'd1;
            r_fstep <= 16'd24576;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_DIMENSION:  r_dim   <= i_cfg_data[4:0];
                REG_SERIES_LEN: r_len   <= i_cfg_data[6:0];
                REG_MAX_K:      r_maxk  <= i_cfg_data[4:0];
                REG_FREQ_STEP:  r_fstep <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cc     <= '0;
            r_wp     <= '0;
            r_filled <= PW'(1);
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cc     <= n_cc;
            r_wp     <= n_wp;
            r_filled <= n_filled;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= n_coord;
        r_p1    <= n_p1;
        r_q     <= n_q;
        r_base  <= n_base;
        r_phase <= n_phase;
        r_k     <= n_k;
        r_quad  <= n_quad;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_i     <= n_i;
        r_cos   <= n_cos;
        r_sin   <= n_sin;
        r_pass  <= n_pass;
        r_j     <= n_j;
        r_mp    <= n_mp;
        r_oval  <= n_oval;
        r_opos  <= n_opos;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

    always_comb begin
        dim_c = (r_dim == 5'd0) ? 5'd1 : ((r_dim > 5'(MAX_DIM)) ? 5'(MAX_DIM) : r_dim);
        len_c = (r_len < 7'd2) ? 7'd2 :
                ((r_len > 7'(SERIES_DEPTH)) ? 7'(SERIES_DEPTH) : r_len);
        cc0     = (r_cc >= dim_c) ? 5'd0 : r_cc;
        cc_inc  = r_cc + 5'd1;
        wp7     = 7'(r_wp);
        filled7 = 7'(r_filled);
        j7      = 7'(r_j);
        out_free = !r_ov || i_m_tready;

        q_rnd = r_q + 62'sd8388608;
        zprod = {31'd0, r_phase[29:0]} * {30'd0, PI_HALF_Q30};
        dx    = r_y >>> r_i;
        dy    = r_x >>> r_i;
        at    = signed'({1'b0, atan_q30(r_i)});
        t_sel = r_pass ? r_sin : r_cos;
        t_ext = 50'(t_sel);
        d_ext = 50'(signed'(ram_rdata));
        mp_rnd = r_mp + 50'sd536870912;
        mp_sh  = mp_rnd >>> 30;
        if (mp_sh > 50'sd16384) begin
            v_sat = ONE_Q14;
        end else if (mp_sh < -50'sd16384) begin
            v_sat = -ONE_Q14;
        end else begin
            v_sat = mp_sh[15:0];
        end
        more = (wp7 + 7'd1 < len_c) &&
               !((j7 + 7'd1 == filled7) && r_pass && (r_k == r_maxk));

        n_state  = r_state;
        n_cc     = r_cc;
        n_wp     = r_wp;
        n_filled = r_filled;
        n_coord  = r_coord;
        n_p1     = r_p1;
        n_q      = r_q;
        n_base   = r_base;
        n_phase  = r_phase;
        n_k      = r_k;
        n_quad   = r_quad;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_i      = r_i;
        n_cos    = r_cos;
        n_sin    = r_sin;
        n_pass   = r_pass;
        n_j      = r_j;
        n_mp     = r_mp;
        n_ov     = r_ov && !i_m_tready;
        n_oval   = r_oval;
        n_opos   = r_opos;
        n_olast  = r_olast;
        n_odone  = r_odone;
        ram_we    = 1'b0;
        ram_waddr = r_wp[AW-1:0];
        ram_wdata = v_sat;
        o_s_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_coord = signed'(i_s_tdata);
                    n_cc    = cc0;
                    n_phase = '0;
                    n_k     = '0;
                    if (cc0 == 5'd0) begin
                        n_wp     = '0;
                        n_filled = PW'(1);
                        n_state  = S_HEAD;
                    end else begin
                        n_state = S_BASE1;
                    end
                end
            end
            S_HEAD: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_oval    = ONE_Q14;
                    n_opos    = '0;
                    n_olast   = (r_maxk == 5'd0);
                    n_odone   = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = ONE_Q14;
                    n_wp      = PW'(1);
                    n_state   = S_BASE1;
                end
            end
            S_BASE1: begin
                n_p1    = 32'(r_coord) * signed'({16'd0, r_fstep});
                n_state = S_BASE2;
            end
            S_BASE2: begin
                n_q     = 62'(r_p1) * 62'(INV2PI_Q32);
                n_state = S_BASE3;
            end
            S_BASE3: begin
                n_base  = q_rnd[55:24];
                n_state = S_HARM;
            end
            S_HARM: begin
                if (r_k >= r_maxk || wp7 >= len_c) begin
                    n_filled = r_wp;
                    n_cc     = (cc_inc >= dim_c) ? 5'd0 : cc_inc;
                    n_state  = S_IDLE;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_phase = r_phase + r_base;
                    n_state = S_ZMUL;
                end
            end
            S_ZMUL: begin
                n_z     = signed'({2'b00, zprod[60:30]});
                n_quad  = r_phase[31:30];
                n_x     = CORDIC_GAIN_Q30;
                n_y     = '0;
                n_i     = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (r_z >= 0) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - at;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + at;
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'(CORDIC_ITERS - 1)) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                case (r_quad)
                    2'd0: begin n_cos = r_x;  n_sin = r_y;  end
                    2'd1: begin n_cos = -r_y; n_sin = r_x;  end
                    2'd2: begin n_cos = -r_x; n_sin = -r_y; end
                    default: begin n_cos = r_y; n_sin = -r_x; end
                endcase
                n_pass  = 1'b0;
                n_j     = '0;
                n_state = S_RD;
            end
            S_RD: begin
                if (j7 < filled7 && wp7 < len_c) begin
                    n_state = S_WAIT;
                end else if (!r_pass) begin
                    n_pass = 1'b1;
                    n_j    = '0;
                end else begin
                    n_state = S_HARM;
                end
            end
            S_WAIT: begin
                n_mp    = t_ext * d_ext;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oval  = v_sat;
                    n_opos  = 6'(r_wp);
                    n_olast = !more;
                    n_odone = (wp7 + 7'd1 == len_c);
                    ram_we  = 1'b1;
                    n_wp    = r_wp + PW'(1);
                    n_j     = r_j + PW'(1);
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_opos, r_oval};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_odone;

endmodule

### hdl/tffe_checker.sv
`include "tensor_fourier_feature_expand_defines.svh"

module tffe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    `TFFE_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    `TFFE_ASSERT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled item changed")

    `TFFE_ASSERT(a_done_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tlast, "series end without end of run")

    `TFFE_ASSERT(a_head_is_one, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[21:16] == 6'd0 |-> o_m_tdata[15:0] == 16'h4000, "entry 0 is not one")

    `TFFE_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready, "ready right after accept")

endmodule

bind tensor_fourier_feature_expand tffe_checker u_tffe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

### tb/tb_tensor_fourier_feature_expand.sv
module tb_tensor_fourier_feature_expand import tffe_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] value;
        logic [5:0]         position;
        logic               last_of_run;
        logic               series_done;
    } t_entry;

    class series_scoreboard;
        t_entry expected_q[$];
        int     errors;
        logic [4:0]  dimension;
        logic [6:0]  series_len;
        logic [4:0]  max_k;
        logic [15:0] freq_step;
        logic signed [15:0] store[64];
        int write_pos;
        int filled_count;
        int coord_count;

        function void reset_state();
            dimension = 1;
            series_len = 64;
            max_k = 1;
            freq_step = 24576;
            write_pos = 0;
            filled_count = 1;
            coord_count = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] v);
            case (idx)
                REG_DIMENSION:  dimension = v[4:0];
                REG_SERIES_LEN: series_len = v[6:0];
                REG_MAX_K:      max_k = v[4:0];
                REG_FREQ_STEP:  freq_step = v;
                default: ;
            endcase
        endfunction

        function longint floor_sh(longint v, int s);
            return v >>> s;
        endfunction

        function void rotate(logic [31:0] ph, output longint c, output longint s);
            longint x, y, z, dx, dy;
            logic [63:0] r;
            r = {34'd0, ph[29:0]} * 64'(PI_HALF_Q30);
            z = longint'(r >> 30);
            x = CORDIC_GAIN_Q30;
            y = 0;
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = floor_sh(y, i);
                dy = floor_sh(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_q30(i[3:0]));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_q30(i[3:0]));
                end
            end
            case (ph[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function logic signed [15:0] scale(longint t, logic signed [15:0] e);
            longint v;
            v = floor_sh(t * longint'(e) + (64'sd1 <<< 29), 30);
            if (v > 16384) v = 16384;
            if (v < -16384) v = -16384;
            return 16'(v);
        endfunction

        function void push(logic signed [15:0] v, int pos, bit done);
            t_entry e;
            e.value = v;
            e.position = pos[5:0];
            e.last_of_run = 1'b0;
            e.series_done = done;
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void note_coord(logic signed [15:0] coord);
            int dim, len, n, first;
            longint p, c, s, t;
            logic [63:0] q;
            logic [31:0] base;
            dim = dimension;
            len = series_len;
            if (dim < 1) dim = 1;
            if (dim > 16) dim = 16;
            if (len < 2) len = 2;
            if (len > 64) len = 64;
            if (coord_count >= dim) coord_count = 0;
            first = expected_q.size();
            n = 0;
            if (coord_count == 0) begin
                filled_count = 1;
                store[0] = 16384;
                push(16384, 0, 0);
                n++;
                write_pos = 1;
            end
            p = longint'(coord) * longint'({1'b0, freq_step});
            q = 64'(p * longint'(INV2PI_Q32)) + (64'd1 << 23);
            base = q[55:24];
            for (int k = 1; k <= max_k && write_pos < len; k++) begin
                rotate(32'(base * k), c, s);
                for (int ps = 0; ps < 2; ps++) begin
                    t = ps ? s : c;
                    for (int j = 0; j < filled_count && write_pos < len; j++) begin
                        store[write_pos] = scale(t, store[j]);
                        push(store[write_pos], write_pos, write_pos + 1 == len);
                        n++;
                        write_pos++;
                    end
                end
            end
            filled_count = write_pos;
            coord_count++;
            if (coord_count >= dim) coord_count = 0;
            if (n > 0) expected_q[first + n - 1].last_of_run = 1'b1;
        endfunction

        function void check_entry(t_entry got);
            t_entry exp_e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected entry %p", got);
                return;
            end
            exp_e = expected_q.pop_front();
            if (got !== exp_e) begin
                errors++;
                if (errors <= 10) $display("mismatch expected %p actual %p", exp_e, got);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid, o_s_tready;
    logic [15:0] i_s_tdata;
    logic        o_m_tvalid, i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast, o_m_tuser;

    series_scoreboard sb;
    bit calm;
    int hold_cycles;

    tensor_fourier_feature_expand uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        t_entry got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.value = o_m_tdata[15:0];
            got.position = o_m_tdata[21:16];
            got.last_of_run = o_m_tlast;
            got.series_done = o_m_tuser;
            sb.check_entry(got);
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) sb.note_coord(i_s_tdata);
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 16);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_coord(logic [15:0] v);
        while (!calm && $urandom_range(99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (600) @(negedge i_clk);
    endtask

    task automatic setup(int dim, int len, int mk, int fs);
        write_reg(REG_DIMENSION, 16'(dim));
        write_reg(REG_SERIES_LEN, 16'(len));
        write_reg(REG_MAX_K, 16'(mk));
        write_reg(REG_FREQ_STEP, 16'(fs));
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_addr = REG_DIMENSION; i_cfg_data = 0;
        i_s_tvalid = 0; i_s_tdata = 0; i_m_tready = 0; calm = 0; hold_cycles = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: defaults, extremes, special register values
        send_coord(16'h0000);
        send_coord(16'h7FFF);
        send_coord(16'h8000);
        send_coord(16'hFFFF);
        drain();
        setup(2, 64, 31, 65535);
        send_coord(16'h1234);
        send_coord(16'hEDCB);
        drain();
        setup(0, 1, 0, 0);
        send_coord(16'h4000);
        send_coord(16'hC000);
        drain();
        setup(31, 127, 3, 12345);
        for (int i = 0; i < 8; i++) send_coord(16'($urandom));
        drain();
        setup(3, 10, 2, 4096);
        send_coord(16'h0800);
        drain();
        write_reg(REG_DIMENSION, 16'd1);
        write_reg(REG_SERIES_LEN, 16'd3);
        send_coord(16'h0100);
        drain();
        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 4);
            setup($urandom_range(1, 16), (ph % 3 == 0) ? $urandom_range(2, 64)
                  : $urandom_range(2, 16), $urandom_range(0, 31) % (ph % 4 == 3 ? 32 : 5),
                  $urandom);
            if (ph == 2) hold_cycles = 3000;
            for (int i = 0; i < 30; i++) send_coord(16'($urandom));
            drain();
        end
        calm = 0;
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
